// ----- rtl/aesb_pkg.sv -----
// Shared types, tables and helper functions for the AES-256 block encryptor.
// Used by aesb_round and aes256_block_encrypt; depends on nothing.
package aesb_pkg;

    typedef struct packed {
        logic [63:0] plain_upper;
        logic [63:0] plain_lower;
    } t_aes_in;

    typedef struct packed {
        logic [63:0] cipher_upper;
        logic [63:0] cipher_lower;
    } t_aes_out;

    typedef enum logic [1:0] {
        CFG_KEY_255_192 = 2'd0,
        CFG_KEY_191_128 = 2'd1,
        CFG_KEY_127_64  = 2'd2,
        CFG_KEY_63_0    = 2'd3
    } t_cfg_idx;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] v);
        sub_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // Round constant number n, counted from zero.
    function automatic logic [7:0] rcon_of(input int n);
        logic [7:0] rc;
        rc = 8'h01;
        for (int k = 0; k < n; k++) begin
            rc = xtime(rc);
        end
        rcon_of = rc;
    endfunction

endpackage

// ----- rtl/aesb_round.sv -----
// One registered AES-256 round together with the next step of the key schedule.
// Depends on aesb_pkg for the S-box, xtime, SubWord and round constants.
module aesb_round #(
    parameter int ROUND_IDX = 1,
    parameter bit IS_LAST   = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [127:0]   i_state,
    input  logic [255:0]   i_win,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [127:0]   o_state,
    output logic [255:0]   o_win
);
    import aesb_pkg::*;

    localparam bit         ROT_STEP = (ROUND_IDX % 2) == 1;
    localparam logic [7:0] RCON     = rcon_of((ROUND_IDX + 1) / 2 - 1);

    logic         r_valid;
    logic [127:0] r_state;
    logic [255:0] r_win;
    logic [127:0] shifted;
    logic [127:0] mixed;
    logic [127:0] n_state;
    logic [255:0] n_win;
    logic [31:0]  key_t;
    logic [31:0]  w0, w1, w2, w3;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shifted[127 - 8 * (4 * c + r) -: 8] =
                    SBOX[i_state[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
    end

    always_comb begin
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = shifted[127 - 32 * c -: 8];
            a1  = shifted[119 - 32 * c -: 8];
            a2  = shifted[111 - 32 * c -: 8];
            a3  = shifted[103 - 32 * c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            mixed[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            mixed[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            mixed[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            mixed[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
    end

    assign n_state = (IS_LAST ? shifted : mixed) ^ i_win[127:0];

    always_comb begin
        if (ROT_STEP) begin
            key_t = sub_word({i_win[23:0], i_win[31:24]}) ^ {RCON, 24'h000000};
        end else begin
            key_t = sub_word(i_win[31:0]);
        end
    end

    assign w0    = i_win[255:224] ^ key_t;
    assign w1    = i_win[223:192] ^ w0;
    assign w2    = i_win[191:160] ^ w1;
    assign w3    = i_win[159:128] ^ w2;
    assign n_win = {i_win[127:0], w0, w1, w2, w3};

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
            r_win   <= n_win;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_win   = r_win;

endmodule

// ----- rtl/aes256_block_encrypt.sv -----
// Top level of the pipelined AES-256 block encryptor.
// Depends on aesb_pkg and aesb_round.
//
// Usage: the 256-bit key is loaded through the write port (i_cfg_we, i_cfg_idx,
// i_cfg_data), one 64-bit register per write, while the pipeline is empty.
// Plaintext blocks enter on the i_in_valid / o_in_ready channel and ciphertext
// leaves on the o_out_valid / i_out_ready channel; a transfer happens on a
// rising edge where valid and ready are both high.
// Every pipeline stage carries its block together with an eight-word window of
// the key schedule, so the schedule is expanded on the fly beside the data.
// There are ROUNDS + 1 register stages: one stage for the initial key addition
// and one per round. A block passes through the key-addition stage and then the
// round stages in order before output valid rises.
// Throughput is one block per cycle while the receiver does not stall, since every
// stage takes a new block in the cycle its current one moves on; the clock period
// is set by one round of S-box lookups plus MixColumns between registers.
// Reset clears every stage valid bit and the key registers to zero.
// When the receiver stalls, full stages hold their data and the ready signal
// ripples back, so nothing is lost or repeated.
module aes256_block_encrypt #(
    parameter int ROUNDS = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  aesb_pkg::t_aes_in i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output aesb_pkg::t_aes_out o_out_data
);
    import aesb_pkg::*;

    logic [255:0] r_key;
    logic         r_valid0;
    logic [127:0] r_state0;
    logic [255:0] r_win0;
    logic         ready0;

    logic         stg_valid [ROUNDS + 1];
    logic         stg_ready [ROUNDS + 1];
    logic [127:0] stg_state [ROUNDS + 1];
    logic [255:0] stg_win   [ROUNDS + 1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_255_192: r_key[255:192] <= i_cfg_data;
                CFG_KEY_191_128: r_key[191:128] <= i_cfg_data;
                CFG_KEY_127_64:  r_key[127:64]  <= i_cfg_data;
                CFG_KEY_63_0:    r_key[63:0]    <= i_cfg_data;
                default:         r_key          <= r_key;
            endcase
        end
    end

    assign ready0 = !r_valid0 || stg_ready[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (ready0) begin
            r_valid0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready0 && i_in_valid) begin
            r_state0 <= {i_in_data.plain_upper, i_in_data.plain_lower} ^ r_key[255:128];
            r_win0   <= r_key;
        end
    end

    assign o_in_ready   = ready0;
    assign stg_valid[0] = r_valid0;
    assign stg_state[0] = r_state0;
    assign stg_win[0]   = r_win0;
    assign stg_ready[0] = ready0;

    for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
        logic         down_ready;
        logic [255:0] win_out;
        if (g == ROUNDS) begin : g_tail
            assign down_ready = i_out_ready;
        end else begin : g_mid
            assign down_ready = stg_ready[g + 1];
        end
        aesb_round #(
            .ROUND_IDX (g),
            .IS_LAST   (g == ROUNDS)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g - 1]),
            .o_ready (stg_ready[g]),
            .i_state (stg_state[g - 1]),
            .i_win   (stg_win[g - 1]),
            .o_valid (stg_valid[g]),
            .i_ready (down_ready),
            .o_state (stg_state[g]),
            .o_win   (win_out)
        );
        assign stg_win[g] = win_out;
    end

    assign o_out_valid             = stg_valid[ROUNDS];
    assign o_out_data.cipher_upper = stg_state[ROUNDS][127:64];
    assign o_out_data.cipher_lower = stg_state[ROUNDS][63:0];

    // The input side can only refuse a transfer when every stage is full and
    // the output is stalled.
    a_full_when_blocked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && r_valid0))
        else $error("input blocked while pipeline has room");

    a_empty_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_valid0))
        else $error("valid bits not cleared by reset");

    // A stalled output stage must keep its ciphertext.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output changed");

endmodule
